[design/sdd_pkg.sv]
// shared types and constants for the s-box difference distribution block
// no dependencies; imported by sdd_ram, sbox_difference_distribution and the testbench
package sdd_pkg;

    localparam int SDD_IN_BITS  = 4;
    localparam int SDD_OUT_BITS = 4;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAX,
        ST_HIST,
        ST_SEL,
        ST_EMIT,
        ST_ERR
    } sdd_state_t;

endpackage

[design/sbox_difference_distribution.sv]
// s-box difference distribution: top level with sequencer, shared comparator
// and count registers; depends on sdd_pkg and sdd_ram
//
// usage:
//   input channel s_*: a load transfer (s_req_type = 0) writes one s-box entry.
//   a query transfer (s_req_type = 1) names an input difference
//   and produces a run of results on the m_* channel, one per output
//   difference with a nonzero pair count, highest count first, ties in
//   ascending difference, m_last on the final one. if the largest entry plus
//   one is not a power of two the run is a single result with m_size_error.
//   a query runs a maximum pass, then builds the histogram (two reads of the
//   s-box ram per index through its one read port), then selects each result
//   (one comparator walks the counts once per emitted entry).
//   s_ready is high only between queries; loads are taken back to back.
//   a stalled receiver holds the output register and the sequencer waits.
//   reset clears the s-box (all entries read as zero) and the output valid.
module sbox_difference_distribution #(
    parameter int IN_BITS  = sdd_pkg::SDD_IN_BITS,
    parameter int OUT_BITS = sdd_pkg::SDD_OUT_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [IN_BITS-1:0]  s_entry_index,
    input  logic [OUT_BITS-1:0] s_entry_value,
    input  logic [IN_BITS-1:0]  s_query_diff,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [OUT_BITS-1:0] m_out_diff,
    output logic [IN_BITS:0]    m_pair_count,
    output logic                m_last,
    output logic                m_size_error
);
    import sdd_pkg::*;

    localparam int IN_SIZE  = 1 << IN_BITS;
    localparam int OUT_SIZE = 1 << OUT_BITS;
    localparam int CNT_W    = IN_BITS + 1;
    localparam int STEP_W   = IN_BITS + 2;
    localparam int CMP_W    = (OUT_BITS > CNT_W) ? OUT_BITS : CNT_W;

    sdd_state_t state_reg, state_next;

    logic [STEP_W-1:0]   idx_reg, idx_next;
    logic [IN_BITS-1:0]  d_reg, d_next;
    logic [OUT_BITS-1:0] maxv_reg, maxv_next;
    logic [OUT_BITS-1:0] a_reg, a_next;
    logic [OUT_BITS-1:0] j_reg, j_next;
    logic [CNT_W-1:0]    best_cnt_reg, best_cnt_next;
    logic [OUT_BITS-1:0] best_o_reg, best_o_next;
    logic [CNT_W-1:0]    remain_reg, remain_next;
    logic [CNT_W-1:0]    cnt_reg [OUT_SIZE];
    logic [IN_SIZE-1:0]  vld_reg;
    logic                rd_ok_reg;

    logic                m_valid_reg, m_valid_next;
    logic [OUT_BITS-1:0] out_diff_reg, out_diff_next;
    logic [CNT_W-1:0]    out_cnt_reg, out_cnt_next;
    logic                out_last_reg, out_last_next;
    logic                out_err_reg, out_err_next;

    logic                load_we;
    logic [IN_BITS-1:0]  ram_raddr;
    logic [OUT_BITS-1:0] ram_rdata;
    logic [OUT_BITS-1:0] rd_val;

    logic [OUT_BITS-1:0] cnt_idx;
    logic [CNT_W-1:0]    cnt_rd;
    logic                cnt_we;
    logic                cnt_clr;
    logic [OUT_BITS-1:0] cnt_widx;
    logic [CNT_W-1:0]    cnt_wdata;

    logic [CMP_W-1:0]    cmp_a;
    logic [CMP_W-1:0]    cmp_b;
    logic                cmp_gt;

    logic [OUT_BITS-1:0] max_now;
    logic [OUT_BITS:0]   span;
    logic                size_bad;
    logic                out_free;

    sdd_ram #(
        .WIDTH (OUT_BITS),
        .DEPTH (IN_SIZE),
        .AW    (IN_BITS)
    ) u_sbox_ram (
        .clk   (aclk),
        .we    (load_we),
        .waddr (s_entry_index),
        .wdata (s_entry_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // entries never written read as zero
    assign rd_val = rd_ok_reg ? ram_rdata : '0;

    assign cnt_rd   = cnt_reg[cnt_idx];
    assign cmp_gt   = cmp_a > cmp_b;
    assign out_free = !m_valid_reg || m_ready;

    assign max_now  = cmp_gt ? rd_val : maxv_reg;
    assign span     = {1'b0, max_now} + 1'b1;
    assign size_bad = ({1'b0, max_now} & span) != '0;

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        d_next        = d_reg;
        maxv_next     = maxv_reg;
        a_next        = a_reg;
        j_next        = j_reg;
        best_cnt_next = best_cnt_reg;
        best_o_next   = best_o_reg;
        remain_next   = remain_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_diff_next = out_diff_reg;
        out_cnt_next  = out_cnt_reg;
        out_last_next = out_last_reg;
        out_err_next  = out_err_reg;
        s_ready       = 1'b0;
        load_we       = 1'b0;
        ram_raddr     = idx_reg[IN_BITS-1:0];
        cnt_idx       = j_reg;
        cnt_we        = 1'b0;
        cnt_clr       = 1'b0;
        cnt_widx      = best_o_reg;
        cnt_wdata     = '0;
        cmp_a         = CMP_W'(cnt_rd);
        cmp_b         = CMP_W'(best_cnt_reg);

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_req_type == REQ_LOAD) begin
                        load_we = 1'b1;
                    end else begin
                        d_next     = s_query_diff;
                        idx_next   = '0;
                        maxv_next  = '0;
                        state_next = ST_MAX;
                    end
                end
            end
            ST_MAX: begin
                // read data arrives in the cycle after its address
                cmp_a = CMP_W'(rd_val);
                cmp_b = CMP_W'(maxv_reg);
                if (idx_reg != '0) begin
                    maxv_next = max_now;
                end
                if (idx_reg == STEP_W'(IN_SIZE)) begin
                    if (size_bad) begin
                        state_next = ST_ERR;
                    end else begin
                        cnt_clr     = 1'b1;
                        idx_next    = '0;
                        remain_next = CNT_W'(IN_SIZE);
                        state_next  = ST_HIST;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_HIST: begin
                // even steps read sbox[i], odd steps read sbox[i ^ d]
                if (idx_reg[0]) begin
                    ram_raddr = idx_reg[IN_BITS:1] ^ d_reg;
                end else begin
                    ram_raddr = idx_reg[IN_BITS:1];
                end
                cnt_idx = a_reg ^ rd_val;
                if (idx_reg != '0) begin
                    if (idx_reg[0]) begin
                        a_next = rd_val;
                    end else begin
                        cnt_we    = 1'b1;
                        cnt_widx  = a_reg ^ rd_val;
                        cnt_wdata = cnt_rd + 1'b1;
                    end
                end
                if (idx_reg == STEP_W'(2 * IN_SIZE)) begin
                    j_next        = '0;
                    best_cnt_next = '0;
                    best_o_next   = '0;
                    state_next    = ST_SEL;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SEL: begin
                if (cmp_gt) begin
                    best_cnt_next = cnt_rd;
                    best_o_next   = j_reg;
                end
                if (&j_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_diff_next = best_o_reg;
                    out_cnt_next  = best_cnt_reg;
                    out_last_next = (remain_reg == best_cnt_reg);
                    out_err_next  = 1'b0;
                    cnt_we        = 1'b1;
                    cnt_widx      = best_o_reg;
                    cnt_wdata     = '0;
                    remain_next   = remain_reg - best_cnt_reg;
                    if (remain_reg == best_cnt_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        j_next        = '0;
                        best_cnt_next = '0;
                        best_o_next   = '0;
                        state_next    = ST_SEL;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_diff_next = '0;
                    out_cnt_next  = '0;
                    out_last_next = 1'b1;
                    out_err_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            vld_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (load_we) begin
                vld_reg[s_entry_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        d_reg        <= d_next;
        maxv_reg     <= maxv_next;
        a_reg        <= a_next;
        j_reg        <= j_next;
        best_cnt_reg <= best_cnt_next;
        best_o_reg   <= best_o_next;
        remain_reg   <= remain_next;
        out_diff_reg <= out_diff_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
        rd_ok_reg    <= vld_reg[ram_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cnt_clr) begin
            for (int k = 0; k < OUT_SIZE; k++) begin
                cnt_reg[k] <= '0;
            end
        end else if (cnt_we) begin
            cnt_reg[cnt_widx] <= cnt_wdata;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_diff   = out_diff_reg;
    assign m_pair_count = out_cnt_reg;
    assign m_last       = out_last_reg;
    assign m_size_error = out_err_reg;

`ifndef SYNTHESIS
    a_err_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_size_error) |-> (m_last && m_pair_count == '0 && m_out_diff == '0))
        else $error("size error result malformed");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_size_error) |-> (m_pair_count != '0))
        else $error("normal result with zero count");

    a_remain_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEL || state_reg == ST_EMIT) |-> (remain_reg != '0))
        else $error("selection running with no pairs left");

    a_emit_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (best_cnt_reg != '0 && best_cnt_reg <= remain_reg))
        else $error("selected count out of range");

    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req_type == REQ_QUERY) |=> !s_ready)
        else $error("query transfer did not start the sequencer");
`endif

endmodule

[design/sdd_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// depends on sdd_pkg for its default parameter sizes
module sdd_ram #(
    parameter int WIDTH = sdd_pkg::SDD_OUT_BITS,
    parameter int DEPTH = 1 << sdd_pkg::SDD_IN_BITS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    import sdd_pkg::*;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[tb/tb_sbox_difference_distribution.sv]
// self-checking testbench for sbox_difference_distribution: loads s-box tables,
// queries difference rows and checks every result against an in-bench predictor
// depends on sdd_pkg and the design sources of sbox_difference_distribution
module tb_sbox_difference_distribution;
    import sdd_pkg::*;

    localparam int IB            = SDD_IN_BITS;
    localparam int OB            = SDD_OUT_BITS;
    localparam int IN_SIZE       = 1 << IB;
    localparam int OUT_SIZE      = 1 << OB;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int STALL_CYCLES  = 600;
    localparam int SETTLE_CYCLES = 400;

    typedef struct packed {
        logic [OB-1:0] out_diff;
        logic [IB:0]   pair_count;
        logic          last;
        logic          size_error;
    } ddt_entry_t;

    logic          aclk;
    logic          aresetn       = 1'b0;
    logic          s_valid       = 1'b0;
    logic          s_ready;
    logic          s_req_type    = REQ_LOAD;
    logic [IB-1:0] s_entry_index = '0;
    logic [OB-1:0] s_entry_value = '0;
    logic [IB-1:0] s_query_diff  = '0;
    logic          m_valid;
    logic          m_ready       = 1'b0;
    logic [OB-1:0] m_out_diff;
    logic [IB:0]   m_pair_count;
    logic          m_last;
    logic          m_size_error;

    logic [OB-1:0] sbox_shadow [IN_SIZE] = '{default: '0};
    ddt_entry_t    ddt_expected [$];
    ddt_entry_t    row_got;
    ddt_entry_t    row_want;
    int            mismatches  = 0;
    int            items_sent  = 0;
    int            cycle_count = 0;
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    logic          rx_stalled  = 1'b0;
    event          rx_hold_ev;

    sbox_difference_distribution dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_entry_index (s_entry_index),
        .s_entry_value (s_entry_value),
        .s_query_diff  (s_query_diff),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_diff    (m_out_diff),
        .m_pair_count  (m_pair_count),
        .m_last        (m_last),
        .m_size_error  (m_size_error)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // long receiver hold-off, counted here
    initial begin
        forever begin
            @(rx_hold_ev);
            rx_stalled <= 1'b1;
            repeat (STALL_CYCLES) @(posedge aclk);
            rx_stalled <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        m_ready <= !rx_stalled && ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            row_got = '{m_out_diff, m_pair_count, m_last, m_size_error};
            if (ddt_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected result diff %0d count %0d last %0b err %0b",
                    row_got.out_diff, row_got.pair_count, row_got.last, row_got.size_error));
            end else begin
                row_want = ddt_expected.pop_front();
                if (row_got.out_diff !== row_want.out_diff)
                    report_mismatch($sformatf("out_diff got %0d want %0d",
                        row_got.out_diff, row_want.out_diff));
                if (row_got.pair_count !== row_want.pair_count)
                    report_mismatch($sformatf("pair_count got %0d want %0d",
                        row_got.pair_count, row_want.pair_count));
                if (row_got.last !== row_want.last)
                    report_mismatch($sformatf("last got %0b want %0b",
                        row_got.last, row_want.last));
                if (row_got.size_error !== row_want.size_error)
                    report_mismatch($sformatf("size_error got %0b want %0b",
                        row_got.size_error, row_want.size_error));
            end
        end
    end

    // expected run of one query: nonzero counts, highest first, ties by difference, or one size-error entry
    task automatic predict_row(input logic [IB-1:0] diff);
        int         hist [OUT_SIZE];
        int         top;
        int         span;
        ddt_entry_t run [$];
        ddt_entry_t ent;
        top = 0;
        foreach (sbox_shadow[i])
            if (int'(sbox_shadow[i]) > top) top = sbox_shadow[i];
        span = top + 1;
        if ((span & (span - 1)) != 0) begin
            ent = '{'0, '0, 1'b1, 1'b1};
            ddt_expected.insert(ddt_expected.size(), ent);
        end else begin
            foreach (hist[o]) hist[o] = 0;
            for (int i = 0; i < IN_SIZE; i++)
                hist[sbox_shadow[i] ^ sbox_shadow[(i ^ int'(diff)) & (IN_SIZE - 1)]]++;
            for (int c = IN_SIZE; c >= 1; c--)
                for (int o = 0; o < OUT_SIZE; o++)
                    if (hist[o] == c) begin
                        ent = '{OB'(o), (IB + 1)'(c), 1'b0, 1'b0};
                        run.insert(run.size(), ent);
                    end
            run[run.size() - 1].last = 1'b1;
            foreach (run[k]) ddt_expected.insert(ddt_expected.size(), run[k]);
        end
    endtask

    // valid is left high after a transfer; the next send or a drain decides its level
    task automatic send_item(input logic req, input logic [IB-1:0] idx,
                             input logic [OB-1:0] val, input logic [IB-1:0] diff);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_entry_index <= idx;
        s_entry_value <= val;
        s_query_diff  <= diff;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (req == REQ_LOAD) sbox_shadow[idx] = val;
        else predict_row(diff);
    endtask

    task automatic send_load(input logic [IB-1:0] idx, input logic [OB-1:0] val);
        send_item(REQ_LOAD, idx, val, IB'($urandom_range(IN_SIZE - 1)));
    endtask

    task automatic send_query(input logic [IB-1:0] diff);
        send_item(REQ_QUERY, IB'($urandom_range(IN_SIZE - 1)),
                  OB'($urandom_range(OUT_SIZE - 1)), diff);
    endtask

    // whole table: a permutation, or random values whose largest entry is top
    task automatic load_table(input bit as_perm, input int top);
        logic [OB-1:0] vals [IN_SIZE];
        logic [OB-1:0] tmp;
        int            j;
        if (as_perm) begin
            foreach (vals[i]) vals[i] = OB'(i);
            for (int i = IN_SIZE - 1; i > 0; i--) begin
                j       = $urandom_range(i);
                tmp     = vals[i];
                vals[i] = vals[j];
                vals[j] = tmp;
            end
        end else begin
            foreach (vals[i]) vals[i] = OB'($urandom_range(top));
            vals[$urandom_range(IN_SIZE - 1)] = OB'(top);
        end
        foreach (vals[i]) send_load(IB'(i), vals[i]);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (ddt_expected.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_query(IB'(0));
        send_query(IB'(IN_SIZE - 1));
        send_load(IB'(IN_SIZE - 1), OB'(OUT_SIZE - 1));
        send_query(IB'(IN_SIZE - 1));
        send_query(IB'(1));
        // largest entry plus one not a power of two
        send_load(IB'(IN_SIZE - 1), OB'(5));
        send_query(IB'(1));
        send_load(IB'(IN_SIZE - 1), OB'(8));
        send_query(IB'(0));
        send_load(IB'(IN_SIZE - 1), OB'(0));
        send_load(IB'(0), OB'(3));
        send_query(IB'(IN_SIZE - 1));
        send_load(IB'(7), OB'(7));
        send_query(IB'(8));
        send_load(IB'(9), OB'(OUT_SIZE - 1));
        send_query(IB'(0));
        send_query(IB'(IN_SIZE - 1));
        send_query(IB'(6));
        send_load(IB'(IN_SIZE - 1), OB'(OUT_SIZE - 2));
        send_load(IB'(9), OB'(0));
        send_query(IB'(3));
        drain_results();
    endtask

    task automatic test_random(input int n_items);
        int first;
        int pick;
        int top;
        first = items_sent;
        while (items_sent - first < n_items) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                if (pick < 25) begin
                    load_table(1'b1, 0);
                end else if (pick < 50) begin
                    load_table(1'b0, (1 << $urandom_range(OB)) - 1);
                end else begin
                    top = $urandom_range(2, OUT_SIZE - 2);
                    while (((top + 1) & top) == 0) top = $urandom_range(2, OUT_SIZE - 2);
                    load_table(1'b0, top);
                end
                repeat ($urandom_range(2, 6)) send_query(IB'($urandom_range(IN_SIZE - 1)));
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 4))
                    send_load(IB'($urandom_range(IN_SIZE - 1)), OB'($urandom_range(OUT_SIZE - 1)));
                repeat ($urandom_range(1, 3)) send_query(IB'($urandom_range(IN_SIZE - 1)));
            end else begin
                repeat ($urandom_range(1, 3))
                    send_load(IB'($urandom_range(IN_SIZE - 1)), OB'($urandom_range(OUT_SIZE - 1)));
            end
        end
        drain_results();
    endtask

    // receiver holds off while queries keep coming, so the input stalls
    task automatic test_backpressure();
        load_table(1'b1, 0);
        -> rx_hold_ev;
        repeat (8) send_query(IB'($urandom_range(1, IN_SIZE - 1)));
        drain_results();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 18;
        rx_idle_pct = 88;
        test_directed();
        test_random(130);
        tx_idle_pct = 88;
        rx_idle_pct = 18;
        test_random(130);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_backpressure();
        test_random(130);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
